// ===== sv/fcr_pkg.sv =====
package fcr_pkg;

    // Layer geometry
    localparam int IN_SIZE  = 64;
    localparam int OUT_SIZE = 16;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 6;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 40;
    localparam int NIDX_W  = 4;
    localparam int FRAC_SH = 8;

    // Store address widths
    localparam int W_DEPTH = OUT_SIZE * IN_SIZE;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int V_AW    = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int B_AW    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int ADDR_W  = W_AW;

    localparam logic [V_AW-1:0] COL_LAST = V_AW'(IN_SIZE - 1);
    localparam logic [B_AW-1:0] NEU_LAST = B_AW'(OUT_SIZE - 1);

    // Queues between and after the two halves (depths are powers of two)
    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = 2;
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Command codes on the input
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_DATA   = 2'd2
    } t_op_kind;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] result;
        logic [NIDX_W-1:0]       neuron_index;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
        logic              fire;
    } t_op;

endpackage

// ===== sv/fully_connected_relu_layer.sv =====
// Dense layer with optional ReLU. Weight and bias words are loaded by command
// beats, data beats fill the input vector in arrival order, and the beat that
// completes the vector launches OUT_SIZE results (bias + dot product, Q24.16)
// in neuron order, the final one flagged last. A front stage classifies beats
// into a four-entry queue; a back stage executes them on one shared
// multiply-accumulate unit fed by a single read port per store. While idle,
// the back stage executes loads and non-final data beats as they come; a
// completed vector keeps it busy until all OUT_SIZE results are queued, and
// input beats keep flowing into the queue during that time until it fills.
// ReLU (reset on) is written through the config channel, which is always
// ready; write it only while the layer is quiet.
module fully_connected_relu_layer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  fcr_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output fcr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import fcr_pkg::*;

    logic r_relu_en;
    logic w_op_valid;
    logic w_op_take;
    t_op  w_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relu_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_relu_en <= i_cfg_data;
        end
    end

    fcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in_item  (i_in_item),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_take  (w_op_take)
    );

    fcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_take  (w_op_take),
        .i_relu_en  (r_relu_en),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_item (o_out_item)
    );

endmodule

// ===== sv/fcr_ram.sv =====
module fcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fcr_front.sv =====
module fcr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  fcr_pkg::t_in_item i_in_item,
    output logic            o_op_valid,
    output fcr_pkg::t_op    o_op,
    input  logic            i_op_take
);
    import fcr_pkg::*;

    t_op             r_mem [IQ_DEPTH];
    logic [IQ_AW-1:0] r_wp;
    logic [IQ_AW-1:0] r_rp;
    logic [IQ_CW-1:0] r_cnt;
    logic [V_AW-1:0]  r_count;
    logic [V_AW-1:0]  n_count;

    logic w_accept;
    logic w_enq;
    logic w_deq;
    t_op  w_op;

    assign o_full     = (r_cnt == IQ_CW'(IQ_DEPTH));
    assign w_accept   = i_push && !o_full;
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_mem[r_rp];
    assign w_deq      = i_op_take && o_op_valid;

    // Classify: drop unused commands and out-of-range loads, tag the closing element
    always_comb begin
        w_enq      = 1'b0;
        w_op.kind  = OP_DATA;
        w_op.addr  = '0;
        w_op.value = i_in_item.value;
        w_op.fire  = 1'b0;
        n_count    = r_count;
        case (i_in_item.command)
            CMD_WEIGHT: begin
                if (int'(i_in_item.row_index) < OUT_SIZE &&
                    int'(i_in_item.column_index) < IN_SIZE) begin
                    w_enq     = 1'b1;
                    w_op.kind = OP_WEIGHT;
                    w_op.addr = ADDR_W'(int'(i_in_item.row_index) * IN_SIZE
                                        + int'(i_in_item.column_index));
                end
            end
            CMD_BIAS: begin
                if (int'(i_in_item.row_index) < OUT_SIZE) begin
                    w_enq     = 1'b1;
                    w_op.kind = OP_BIAS;
                    w_op.addr = ADDR_W'(i_in_item.row_index);
                end
            end
            CMD_DATA: begin
                w_enq     = 1'b1;
                w_op.kind = OP_DATA;
                w_op.addr = ADDR_W'(r_count);
                w_op.fire = (r_count == COL_LAST);
                n_count   = (r_count == COL_LAST) ? '0 : r_count + 1'b1;
            end
            default: begin
                w_enq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept && w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            if ((w_accept && w_enq) && !w_deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!(w_accept && w_enq) && w_deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_enq) begin
            r_mem[r_wp] <= w_op;
        end
    end

endmodule

// ===== sv/fcr_back.sv =====
module fcr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  fcr_pkg::t_op      i_op,
    output logic              o_op_take,
    input  logic              i_relu_en,
    output logic              o_empty,
    input  logic              i_pop,
    output fcr_pkg::t_out_item o_out_item
);
    import fcr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [V_AW-1:0] r_col;
    logic [B_AW-1:0] r_neu;
    logic [W_AW-1:0] r_waddr;

    logic                    r_s1_vld;
    logic                    r_s1_first;
    logic                    r_s1_last;
    logic                    r_s2_vld;
    logic                    r_s2_first;
    logic                    r_s2_last;
    logic signed [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0]        r_bias;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_acc_done;

    logic [VAL_W-1:0] w_wdata;
    logic [VAL_W-1:0] w_vdata;
    logic [VAL_W-1:0] w_bdata;

    logic w_take;
    logic w_issue;
    logic w_push;
    logic w_start;
    logic signed [ACC_W-1:0] w_bias_ext;
    logic signed [ACC_W-1:0] w_base;
    t_out_item w_res;

    t_out_item        r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp;
    logic [OQ_AW-1:0] r_orp;
    logic [OQ_CW-1:0] r_ocnt;
    logic             w_oq_full;
    logic             w_oq_pop;

    assign w_oq_full  = (r_ocnt == OQ_CW'(OQ_DEPTH));
    assign o_empty    = (r_ocnt == '0);
    assign o_out_item = r_oq[r_orp];
    assign w_oq_pop   = i_pop && !o_empty;
    assign o_op_take  = w_take;
    assign w_start    = w_take && (i_op.kind == OP_DATA) && i_op.fire;

    fcr_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_take && (i_op.kind == OP_WEIGHT)),
        .i_waddr (i_op.addr[W_AW-1:0]),
        .i_wdata (i_op.value),
        .i_raddr (r_waddr),
        .o_rdata (w_wdata)
    );

    fcr_ram #(.WIDTH(VAL_W), .DEPTH(IN_SIZE)) u_vector_ram (
        .i_clk   (i_clk),
        .i_we    (w_take && (i_op.kind == OP_DATA)),
        .i_waddr (i_op.addr[V_AW-1:0]),
        .i_wdata (i_op.value),
        .i_raddr (r_col),
        .o_rdata (w_vdata)
    );

    fcr_ram #(.WIDTH(VAL_W), .DEPTH(OUT_SIZE)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_take && (i_op.kind == OP_BIAS)),
        .i_waddr (i_op.addr[B_AW-1:0]),
        .i_wdata (i_op.value),
        .i_raddr (r_neu),
        .o_rdata (w_bdata)
    );

    always_comb begin
        n_state = r_state;
        w_take  = 1'b0;
        w_issue = 1'b0;
        w_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    w_take = 1'b1;
                    if (i_op.kind == OP_DATA && i_op.fire) begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                w_issue = 1'b1;
                if (r_col == COL_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_acc_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!w_oq_full) begin
                    w_push  = 1'b1;
                    n_state = (r_neu == NEU_LAST) ? S_IDLE : S_MAC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bias in Q8.8 moves up to Q24.16 before the products land on it
    assign w_bias_ext = ACC_W'(signed'({r_bias, {FRAC_SH{1'b0}}}));
    assign w_base     = r_s2_first ? w_bias_ext : r_acc;

    always_comb begin
        w_res.result       = (i_relu_en && r_acc[ACC_W-1]) ? '0 : r_acc;
        w_res.neuron_index = NIDX_W'(r_neu);
        w_res.last         = (r_neu == NEU_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_neu      <= '0;
            r_waddr    <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
        end else begin
            r_state    <= n_state;
            r_s1_vld   <= w_issue;
            r_s2_vld   <= r_s1_vld;
            r_acc_done <= r_s2_vld && r_s2_last;
            if (w_start) begin
                r_col   <= '0;
                r_neu   <= '0;
                r_waddr <= '0;
            end
            if (w_issue) begin
                r_col   <= (r_col == COL_LAST) ? '0 : r_col + 1'b1;
                r_waddr <= r_waddr + 1'b1;
            end
            if (w_push) begin
                r_neu <= (r_neu == NEU_LAST) ? '0 : r_neu + 1'b1;
                r_owp <= r_owp + 1'b1;
            end
            if (w_oq_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            if (w_push && !w_oq_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!w_push && w_oq_pop) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_col == '0);
        r_s1_last  <= (r_col == COL_LAST);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s1_vld) begin
            r_prod <= signed'(w_vdata) * signed'(w_wdata);
            if (r_s1_first) begin
                r_bias <= w_bdata;
            end
        end
        if (r_s2_vld) begin
            r_acc <= w_base + ACC_W'(r_prod);
        end
        if (w_push) begin
            r_oq[r_owp] <= w_res;
        end
    end

endmodule

// ===== sv/fcr_checker.sv =====
module fcr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input fcr_pkg::t_out_item o_out_item
);
    import fcr_pkg::*;

    // Only the final neuron carries the last flag
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.last) |-> (o_out_item.neuron_index == NIDX_W'(OUT_SIZE - 1)))
        else $error("last flag on a neuron other than the final one");

    // Results of one vector come out in neuron order
    a_neuron_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_out_item.last) ##1 !empty |->
            (o_out_item.neuron_index == $past(o_out_item.neuron_index) + 1'b1))
        else $error("neuron index did not advance by one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed before it was taken");

endmodule

bind fully_connected_relu_layer fcr_checker u_fcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fcr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int TIMEOUT_NS   = 8_000_000;
    localparam int SETTLE       = 24;
    localparam int TAIL         = 40;
    localparam int LONG_HOLD    = 3000;
    localparam int RAND_ITEMS   = 360;
    localparam int PHASE_ITEMS  = 90;
    localparam int MIN_RESULTS  = 64;
    localparam int PRINT_CAP    = 100;
    localparam int N_STEPS      = 14;

    // Spare command code; the layer drops it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic {
        STEP_BEAT = 1'b0,
        STEP_RELU = 1'b1
    } t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        logic [CMD_W-1:0]        command;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [VAL_W-1:0]        value;
        logic [7:0]              reps;
        logic                    typed;
        logic signed [ACC_W-1:0] want;
    } t_step;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      push        = 1'b0;
    logic      full;
    t_in_item  i_in_item   = '0;
    logic      empty;
    logic      pop         = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data  = 1'b0;

    // Layer state as the layer should hold it
    logic signed [VAL_W-1:0] weight_mem [OUT_SIZE][IN_SIZE];
    logic signed [VAL_W-1:0] bias_mem   [OUT_SIZE];
    logic signed [VAL_W-1:0] vector_mem [IN_SIZE];
    int                      elements_held = 0;
    bit                      relu_on       = 1'b1;
    t_out_item               layer_results [OUT_SIZE];

    t_out_item layer_outputs [$];
    int        errors          = 0;
    int        predicted_total = 0;
    int        tx_sent         = 0;
    bit        tx_burst        = 1'b0;
    bit        hold_rx         = 1'b0;

    // Loads start from all-zero weights and biases of 16'h7FFF, so the first vector
    // gives the shifted bias on every neuron.
    t_step steps [N_STEPS] = '{
        '{STEP_BEAT, CMD_UNUSED, 4'd15, 6'd63, 16'hFFFF, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_UNUSED, 4'd0,  6'd0,  16'h0000, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_DATA,   4'd0,  6'd0,  16'h8000, 8'd63, 1'b0, 40'sd0},
        '{STEP_BEAT, CMD_DATA,   4'd15, 6'd63, 16'h7FFF, 8'd1,  1'b1, 40'sh00007FFF00},
        '{STEP_BEAT, CMD_BIAS,   4'd0,  6'd0,  16'h8000, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_BIAS,   4'd15, 6'd63, 16'h0000, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_WEIGHT, 4'd15, 6'd63, 16'h8000, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_WEIGHT, 4'd15, 6'd0,  16'h7FFF, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_WEIGHT, 4'd0,  6'd63, 16'h7FFF, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_WEIGHT, 4'd1,  6'd62, 16'hFFFF, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_DATA,   4'd0,  6'd0,  16'h8000, 8'd63, 1'b0, 40'sd0},
        '{STEP_BEAT, CMD_DATA,   4'd15, 6'd63, 16'h7FFF, 8'd1,  1'b0, 40'sd0},
        '{STEP_RELU, CMD_DATA,   4'd0,  6'd0,  16'h0000, 8'd1,  1'b0, 40'sd0},
        '{STEP_BEAT, CMD_DATA,   4'd0,  6'd0,  16'h7FFF, 8'd64, 1'b0, 40'sd0}
    };

    fully_connected_relu_layer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        // stay quiet after the first hundred, keep counting
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Apply one beat to the layer state; returns how many neuron outputs it fires.
    function automatic int run_layer(input t_in_item it);
        logic signed [ACC_W-1:0]   acc;
        logic signed [2*VAL_W-1:0] prod;
        int                        n;
        int                        i;
        case (it.command)
            CMD_WEIGHT: begin
                if (int'(it.row_index) < OUT_SIZE && int'(it.column_index) < IN_SIZE)
                    weight_mem[it.row_index][it.column_index] = it.value;
                return 0;
            end
            CMD_BIAS: begin
                if (int'(it.row_index) < OUT_SIZE)
                    bias_mem[it.row_index] = it.value;
                return 0;
            end
            CMD_DATA: begin
                if (elements_held >= IN_SIZE)
                    elements_held = 0;
                vector_mem[elements_held] = it.value;
                elements_held++;
                if (elements_held < IN_SIZE)
                    return 0;
                elements_held = 0;
                for (n = 0; n < OUT_SIZE; n++) begin
                    acc = ACC_W'(bias_mem[n]) <<< FRAC_SH;
                    for (i = 0; i < IN_SIZE; i++) begin
                        prod = (2*VAL_W)'(vector_mem[i]) * (2*VAL_W)'(weight_mem[n][i]);
                        acc  = acc + ACC_W'(prod);
                    end
                    if (relu_on && acc[ACC_W-1])
                        acc = '0;
                    layer_results[n] = '{result: acc, neuron_index: NIDX_W'(n),
                                         last: (n == OUT_SIZE - 1)};
                end
                return OUT_SIZE;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Offer one beat after a random gap; leave push high for a back-to-back follower.
    task automatic send_beat(input t_in_item it, input bit typed,
                             input logic signed [ACC_W-1:0] want);
        int        gap;
        int        n;
        int        k;
        t_out_item o;
        if (tx_sent % 32 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        tx_sent++;
        n = run_layer(it);
        for (k = 0; k < n; k++) begin
            o = layer_results[k];
            if (typed)
                o = '{result: want, neuron_index: NIDX_W'(k), last: (k == OUT_SIZE - 1)};
            layer_outputs.push_back(o);
        end
        predicted_total += n;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (layer_outputs.size() != 0) @(posedge i_clk);
        // trailing loads may still sit in the input queue
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_relu(input bit on);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= on;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        relu_on = on;
    endtask

    // Write every weight and bias: zeros and 16'h7FFF, or random words.
    task automatic load_all(input bit scramble);
        t_in_item beat;
        int       r;
        int       c;
        for (r = 0; r < OUT_SIZE; r++) begin
            for (c = 0; c < IN_SIZE; c++) begin
                beat = '{command: CMD_WEIGHT, row_index: ROW_W'(r), column_index: COL_W'(c),
                         value: scramble ? pick_value() : 16'h0000};
                send_beat(beat, 1'b0, '0);
            end
            beat = '{command: CMD_BIAS, row_index: ROW_W'(r), column_index: COL_W'($urandom),
                     value: scramble ? pick_value() : 16'h7FFF};
            send_beat(beat, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_in_item beat;
        int       s;
        int       k;
        int       ph;
        int       sent;
        int       base;
        int       pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_all(1'b0);
        for (s = 0; s < N_STEPS; s++) begin
            if (steps[s].kind == STEP_RELU) begin
                write_relu(steps[s].value[0]);
            end else begin
                beat = '{command: steps[s].command, row_index: steps[s].row,
                         column_index: steps[s].col, value: steps[s].value};
                for (k = 0; k < int'(steps[s].reps); k++)
                    send_beat(beat, steps[s].typed, steps[s].want);
            end
        end

        load_all(1'b1);
        base = predicted_total;
        sent = 0;
        ph   = 0;
        while (sent < RAND_ITEMS || predicted_total - base < MIN_RESULTS) begin
            write_relu(ph % 2 == 0);
            if (ph == 0)
                hold_rx = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == PHASE_ITEMS / 2)
                    wait_drained();
                pick = $urandom_range(0, 99);
                beat.row_index    = ROW_W'($urandom);
                beat.column_index = COL_W'($urandom);
                beat.value        = pick_value();
                if (pick < 72)
                    beat.command = CMD_DATA;
                else if (pick < 86)
                    beat.command = CMD_WEIGHT;
                else if (pick < 95)
                    beat.command = CMD_BIAS;
                else
                    beat.command = CMD_UNUSED;
                send_beat(beat, 1'b0, '0);
                if (beat.command != CMD_UNUSED)
                    sent++;
            end
            ph++;
        end

        wait_drained();
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0 && layer_outputs.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin : result_drain
        t_out_item got;
        t_out_item want;
        int        gap;
        int        beats;
        bit        rx_burst;
        beats    = 0;
        rx_burst = 1'b0;
        forever begin
            if (hold_rx) begin
                // back up the layer until it stalls its input
                hold_rx = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (beats % 32 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
                gap = rx_burst ? 0 : $urandom_range(0, 15);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty || !i_rst_n);
            got = o_out_item;
            beats++;
            if (layer_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output, neuron %0d result %0d",
                                          got.neuron_index, got.result));
            end else begin
                want = layer_outputs.pop_front();
                if (got.result !== want.result)
                    report_mismatch($sformatf("neuron %0d result: got %0d, want %0d",
                                              want.neuron_index, got.result, want.result));
                if (got.neuron_index !== want.neuron_index)
                    report_mismatch($sformatf("neuron_index: got %0d, want %0d",
                                              got.neuron_index, want.neuron_index));
                if (got.last !== want.last)
                    report_mismatch($sformatf("neuron %0d last: got %0b, want %0b",
                                              want.neuron_index, got.last, want.last));
            end
        end
    end

endmodule
